@@ src/tlc_pkg.sv @@
// tlc_pkg: codes, tables and digit helpers for the traffic light controller
// no dependencies; imported by traffic_light_controller

package tlc_pkg;

  localparam int unsigned DigitCount = 4;
  localparam int unsigned DefMaxDuration = 99;

  // request codes carried in req_type
  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqPoll  = 2'd1;
  localparam logic [1:0] ReqScan  = 2'd2;
  localparam logic [1:0] ReqBlink = 2'd3;

  // phase codes
  localparam logic [2:0] PhRedGreen   = 3'd0;
  localparam logic [2:0] PhRedAmber   = 3'd1;
  localparam logic [2:0] PhGreenRed   = 3'd2;
  localparam logic [2:0] PhAmberRed   = 3'd3;
  localparam logic [2:0] PhEditRed    = 3'd4;
  localparam logic [2:0] PhEditAmber  = 3'd5;
  localparam logic [2:0] PhEditGreen  = 3'd6;

  // lamp masks, bits 0-2 road one, bits 3-5 road two
  localparam logic [5:0] BlinkRed   = 6'h09;
  localparam logic [5:0] BlinkAmber = 6'h12;
  localparam logic [5:0] BlinkGreen = 6'h24;

  function automatic logic [5:0] auto_lamps(input logic [1:0] ph);
    logic [5:0] l;
    case (ph)
      2'd0:    l = 6'h21;
      2'd1:    l = 6'h11;
      2'd2:    l = 6'h0C;
      default: l = 6'h0A;
    endcase
    return l;
  endfunction

  // active-low segments a..g, bit0 = a
  function automatic logic [6:0] seg_decode(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h40;
      4'd1:    s = 7'h79;
      4'd2:    s = 7'h24;
      4'd3:    s = 7'h30;
      4'd4:    s = 7'h19;
      4'd5:    s = 7'h12;
      4'd6:    s = 7'h02;
      4'd7:    s = 7'h78;
      4'd8:    s = 7'h00;
      default: s = 7'h10;
    endcase
    return s;
  endfunction

  // quotient and remainder by ten: {q, r}; exact for values below 160, as q keeps 4 bits
  function automatic logic [7:0] div10(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  qx10;
    logic [3:0]  r;
    prod = v * 16'd205;
    q    = prod[15:11];
    qx10 = {3'b000, q} * 8'd10;
    r    = 4'(v - qx10);
    return {q[3:0], r};
  endfunction

  // signed counter to two stored digit codes {hi, lo}, negatives kept as low 4 bits
  function automatic logic [7:0] split_count(input logic [7:0] c);
    logic [7:0] mag;
    logic [7:0] qr;
    logic [3:0] hi;
    logic [3:0] lo;
    mag = c[7] ? (8'd0 - c) : c;
    qr  = div10(mag);
    hi  = c[7] ? (4'd0 - qr[7:4]) : qr[7:4];
    lo  = c[7] ? (4'd0 - qr[3:0]) : qr[3:0];
    return {hi, lo};
  endfunction

  function automatic logic [7:0] minus_one(input logic [6:0] d);
    return {1'b0, d} - 8'd1;
  endfunction

endpackage

@@ src/traffic_light_controller.sv @@
// traffic_light_controller: two-road light sequencer with duration editing
// and a multiplexed four-digit display; depends on tlc_pkg
//
//  channel | direction | beat holds
//  in      | sink      | req_type, press_mode, press_increase, press_confirm
//  out     | source    | road_one_lamps, road_two_lamps, digit_select,
//          |           | segment_pattern, current_phase
//
// one beat in, one beat out; each input beat is handled by the combinational
// next-state logic and lands in the state registers, which feed the outputs
// a new beat is taken every cycle while the result slot is empty or being taken
// an output stall holds the input off until the waiting result is taken
// reset (async, active low) restores phase red-green, counters 5 and 3,
// durations 5/2/3, blank display and lamps off

module traffic_light_controller
  import tlc_pkg::*;
#(
  parameter int unsigned MAX_DURATION = DefMaxDuration
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic       press_mode_i,
  input  logic       press_increase_i,
  input  logic       press_confirm_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] road_one_lamps_o,
  output logic [2:0] road_two_lamps_o,
  output logic [1:0] digit_select_o,
  output logic [6:0] segment_pattern_o,
  output logic [2:0] current_phase_o
);

  localparam logic [6:0] MaxDur = 7'(MAX_DURATION);

  logic       out_valid_q;
  logic [2:0] phase_q, phase_d;
  logic [7:0] cnt1_q, cnt1_d;
  logic [7:0] cnt2_q, cnt2_d;
  logic [6:0] red_q, red_d;
  logic [6:0] amber_q, amber_d;
  logic [6:0] green_q, green_d;
  logic [6:0] edit_q, edit_d;
  logic [3:0] digit_q [DigitCount];
  logic [3:0] digit_d [DigitCount];
  logic [1:0] scan_q, scan_d;
  logic [5:0] lamp_q, lamp_d;
  logic [6:0] seg_q, seg_d;
  logic       in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    logic [7:0] sum;
    logic [7:0] split1;
    logic [7:0] split2;
    logic [7:0] edit_qr;
    logic [3:0] cur_digit;
    logic [5:0] mask;
    phase_d = phase_q;
    cnt1_d  = cnt1_q;
    cnt2_d  = cnt2_q;
    red_d   = red_q;
    amber_d = amber_q;
    green_d = green_q;
    edit_d  = edit_q;
    digit_d = digit_q;
    scan_d  = scan_q;
    lamp_d  = lamp_q;
    seg_d   = seg_q;
    sum     = '0;
    mask    = '0;
    split1  = split_count(cnt1_q);
    split2  = split_count(cnt2_q);
    edit_qr = div10({1'b0, edit_q});
    cur_digit = digit_q[scan_q];

    case (req_type_i)
      ReqTick: begin
        if (phase_q <= PhAmberRed) begin
          cnt1_d = cnt1_q - 8'd1;
          cnt2_d = cnt2_q - 8'd1;
          if (cnt1_d[7] || cnt2_d[7]) begin
            case (phase_q)
              PhRedGreen: begin
                phase_d = PhRedAmber;
                cnt2_d  = minus_one(amber_q);
              end
              PhRedAmber: begin
                phase_d = PhGreenRed;
                cnt1_d  = minus_one(green_q);
                cnt2_d  = minus_one(red_q);
              end
              PhGreenRed: begin
                phase_d = PhAmberRed;
                cnt1_d  = minus_one(amber_q);
              end
              default: begin
                phase_d = PhRedGreen;
                cnt1_d  = minus_one(red_q);
                cnt2_d  = minus_one(green_q);
              end
            endcase
          end
          lamp_d = auto_lamps(phase_d[1:0]);
        end
      end

      ReqPoll: begin
        // display store follows the phase held before the buttons act
        if (phase_q inside {PhEditRed, PhEditAmber, PhEditGreen}) begin
          digit_d[0] = 4'd0;
          digit_d[1] = {1'b0, phase_q - 3'd2};
          digit_d[2] = edit_qr[7:4];
          digit_d[3] = edit_qr[3:0];
        end else begin
          digit_d[0] = split1[7:4];
          digit_d[1] = split1[3:0];
          digit_d[2] = split2[7:4];
          digit_d[3] = split2[3:0];
        end

        if (press_mode_i) begin
          case (phase_q)
            PhRedGreen, PhRedAmber, PhGreenRed, PhAmberRed: begin
              edit_d  = red_q;
              phase_d = PhEditRed;
            end
            PhEditRed: begin
              edit_d  = amber_q;
              phase_d = PhEditAmber;
            end
            PhEditAmber: begin
              edit_d  = green_q;
              phase_d = PhEditGreen;
            end
            PhEditGreen: begin
              cnt1_d  = minus_one(red_q);
              cnt2_d  = minus_one(green_q);
              phase_d = PhRedGreen;
            end
            default: ;
          endcase
        end

        if (press_increase_i && (phase_d inside {PhEditRed, PhEditAmber, PhEditGreen})) begin
          edit_d = edit_d + 7'd1;
          if (edit_d > MaxDur) edit_d = 7'd1;
        end

        // keep red equal to green plus amber
        if (press_confirm_i) begin
          case (phase_d)
            PhEditRed: begin
              red_d = edit_d;
              sum   = {1'b0, green_q} + {1'b0, amber_q};
              if ({1'b0, red_d} >= sum) begin
                green_d = red_d - amber_q;
              end else begin
                amber_d = red_d >> 1;
                green_d = red_d - (red_d >> 1);
              end
            end
            PhEditAmber: begin
              amber_d = edit_d;
              sum     = {1'b0, amber_d} + {1'b0, green_q};
              if ({1'b0, red_q} >= sum) begin
                green_d = red_q - amber_d;
              end else if (sum <= {1'b0, MaxDur}) begin
                red_d = sum[6:0];
              end else begin
                red_d   = MaxDur;
                green_d = MaxDur - amber_d;
              end
            end
            PhEditGreen: begin
              green_d = edit_d;
              sum     = {1'b0, green_d} + {1'b0, amber_q};
              if ({1'b0, red_q} >= sum) begin
                amber_d = red_q - green_d;
              end else if (sum <= {1'b0, MaxDur}) begin
                red_d = sum[6:0];
              end else begin
                red_d   = MaxDur;
                amber_d = MaxDur - green_d;
              end
            end
            default: ;
          endcase
        end
      end

      ReqScan: begin
        // codes above nine leave the last pattern on the display
        if (cur_digit <= 4'd9) seg_d = seg_decode(cur_digit);
        scan_d = scan_q + 2'd1;
      end

      default: begin
        case (phase_q)
          PhEditRed:   mask = BlinkRed;
          PhEditAmber: mask = BlinkAmber;
          PhEditGreen: mask = BlinkGreen;
          default:     mask = '0;
        endcase
        if (mask != '0) lamp_d = (lamp_q & mask) ^ mask;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= PhRedGreen;
      cnt1_q      <= 8'd5;
      cnt2_q      <= 8'd3;
      red_q       <= 7'd5;
      amber_q     <= 7'd2;
      green_q     <= 7'd3;
      edit_q      <= 7'd0;
      for (int i = 0; i < DigitCount; i++) digit_q[i] <= 4'd0;
      scan_q      <= 2'd0;
      lamp_q      <= 6'd0;
      seg_q       <= 7'h7F;
    end else begin
      if (in_fire) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        cnt1_q      <= cnt1_d;
        cnt2_q      <= cnt2_d;
        red_q       <= red_d;
        amber_q     <= amber_d;
        green_q     <= green_d;
        edit_q      <= edit_d;
        digit_q     <= digit_d;
        scan_q      <= scan_d;
        lamp_q      <= lamp_d;
        seg_q       <= seg_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign road_one_lamps_o  = lamp_q[2:0];
  assign road_two_lamps_o  = lamp_q[5:3];
  assign digit_select_o    = scan_q - 2'd1;
  assign segment_pattern_o = seg_q;
  assign current_phase_o   = phase_q;

  // the red duration never exceeds the cap once confirmed
  a_red_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_q <= MaxDur)
    else $error("red duration above cap");

  // a tick in an automatic phase holds or steps to the next automatic phase
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req_type_i == ReqTick && phase_q <= PhAmberRed) |=>
      (phase_q == $past(phase_q)) ||
      (phase_q == {1'b0, 2'($past(phase_q) + 3'd1)}))
    else $error("tick moved phase out of sequence");

  // scan beat steps the digit position by one
  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req_type_i == ReqScan) |=> scan_q == $past(scan_q) + 2'd1)
    else $error("scan position did not advance");

endmodule

@@ verif/tb_traffic_light_controller.sv @@
// tb_traffic_light_controller: self-checking bench for the two-road light controller
// predicts lamps, phase and display per beat and compares every output beat in order
// depends on tlc_pkg and traffic_light_controller

module tb_traffic_light_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import tlc_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic [2:0] road_one;
    logic [2:0] road_two;
    logic [1:0] digit_sel;
    logic [6:0] segments;
    logic [2:0] phase;
  } lights_t;

  class light_scoreboard;
    logic [2:0] phase_q;
    logic [7:0] cnt_one;
    logic [7:0] cnt_two;
    logic [6:0] red_d;
    logic [6:0] amber_d;
    logic [6:0] green_d;
    logic [6:0] edit_d;
    logic [3:0] digits[4];
    logic [1:0] scan_pos;
    logic [5:0] lamps;
    logic [6:0] segs;
    lights_t    pending_lights[$];
    int         mismatch_count;

    function new();
      phase_q = PhRedGreen;
      cnt_one = 8'd5;
      cnt_two = 8'd3;
      red_d = 7'd5;
      amber_d = 7'd2;
      green_d = 7'd3;
      edit_d = 7'd0;
      foreach (digits[n]) digits[n] = 4'd0;
      scan_pos = 2'd0;
      lamps = 6'h00;
      segs = 7'h7f;
      mismatch_count = 0;
    endfunction

    function logic [7:0] reload_of(logic [6:0] d);
      return 8'(d) - 8'd1;
    endfunction

    // signed counter as two stored codes {tens, units}, negatives kept as low nibble
    function logic [7:0] count_digits(logic [7:0] c);
      logic [7:0] mag;
      logic [3:0] q;
      logic [3:0] r;
      mag = c[7] ? (8'd0 - c) : c;
      q = 4'(mag / 8'd10);
      r = 4'(mag % 8'd10);
      return c[7] ? {4'd0 - q, 4'd0 - r} : {q, r};
    endfunction

    function logic [6:0] segments_for(logic [3:0] d);
      logic [6:0] s;
      case (d)
        4'd0: s = 7'h40;
        4'd1: s = 7'h79;
        4'd2: s = 7'h24;
        4'd3: s = 7'h30;
        4'd4: s = 7'h19;
        4'd5: s = 7'h12;
        4'd6: s = 7'h02;
        4'd7: s = 7'h78;
        4'd8: s = 7'h00;
        default: s = 7'h10;
      endcase
      return s;
    endfunction

    function bit editing();
      return phase_q >= PhEditRed && phase_q <= PhEditGreen;
    endfunction

    function void refresh_digits();
      if (editing()) begin
        digits[0] = 4'd0;
        digits[1] = 4'(phase_q - 3'd2);
        digits[2] = 4'(edit_d / 7'd10);
        digits[3] = 4'(edit_d % 7'd10);
      end else begin
        {digits[0], digits[1]} = count_digits(cnt_one);
        {digits[2], digits[3]} = count_digits(cnt_two);
      end
    endfunction

    function void second_tick();
      if (phase_q > PhAmberRed) return;
      cnt_one = cnt_one - 8'd1;
      cnt_two = cnt_two - 8'd1;
      if (cnt_one[7] || cnt_two[7]) begin
        case (phase_q)
          PhRedGreen: begin
            phase_q = PhRedAmber;
            cnt_two = reload_of(amber_d);
          end
          PhRedAmber: begin
            phase_q = PhGreenRed;
            cnt_one = reload_of(green_d);
            cnt_two = reload_of(red_d);
          end
          PhGreenRed: begin
            phase_q = PhAmberRed;
            cnt_one = reload_of(amber_d);
          end
          default: begin
            phase_q = PhRedGreen;
            cnt_one = reload_of(red_d);
            cnt_two = reload_of(green_d);
          end
        endcase
      end
      case (phase_q)
        PhRedGreen: lamps = 6'h21;
        PhRedAmber: lamps = 6'h11;
        PhGreenRed: lamps = 6'h0c;
        default:    lamps = 6'h0a;
      endcase
    endfunction

    // keep red = green + amber, clamped at the maximum duration
    function void confirm_edit();
      int unsigned rd;
      int unsigned ed;
      int unsigned ot;
      rd = red_d;
      ed = edit_d;
      case (phase_q)
        PhEditRed: begin
          red_d = edit_d;
          if (ed >= int'(green_d) + int'(amber_d)) begin
            green_d = red_d - amber_d;
          end else begin
            amber_d = red_d / 7'd2;
            green_d = red_d - red_d / 7'd2;
          end
        end
        PhEditAmber, PhEditGreen: begin
          ot = (phase_q == PhEditAmber) ? green_d : amber_d;
          if (rd >= ed + ot) begin
            ot = rd - ed;
          end else if (ed + ot <= DefMaxDuration) begin
            rd = ed + ot;
          end else begin
            rd = DefMaxDuration;
            ot = DefMaxDuration - ed;
          end
          red_d = 7'(rd);
          if (phase_q == PhEditAmber) begin
            amber_d = 7'(ed);
            green_d = 7'(ot);
          end else begin
            green_d = 7'(ed);
            amber_d = 7'(ot);
          end
        end
        default: ;
      endcase
    endfunction

    function void button_poll(logic mode, logic incr, logic conf);
      refresh_digits();
      if (mode) begin
        case (phase_q)
          PhRedGreen, PhRedAmber, PhGreenRed, PhAmberRed: begin
            edit_d = red_d;
            phase_q = PhEditRed;
          end
          PhEditRed: begin
            edit_d = amber_d;
            phase_q = PhEditAmber;
          end
          PhEditAmber: begin
            edit_d = green_d;
            phase_q = PhEditGreen;
          end
          PhEditGreen: begin
            cnt_one = reload_of(red_d);
            cnt_two = reload_of(green_d);
            phase_q = PhRedGreen;
          end
          default: ;
        endcase
      end
      if (incr && editing()) begin
        edit_d = edit_d + 7'd1;
        if (edit_d > 7'(DefMaxDuration)) edit_d = 7'd1;
      end
      if (conf) confirm_edit();
    endfunction

    function void scan_digit();
      if (digits[scan_pos] <= 4'd9) segs = segments_for(digits[scan_pos]);
      scan_pos = scan_pos + 2'd1;
    endfunction

    function void blink_lamps();
      logic [5:0] mask;
      case (phase_q)
        PhEditRed:   mask = BlinkRed;
        PhEditAmber: mask = BlinkAmber;
        PhEditGreen: mask = BlinkGreen;
        default:     return;
      endcase
      lamps = (lamps & mask) ^ mask;
    endfunction

    function void note_request(logic [1:0] req, logic mode, logic incr, logic conf);
      lights_t want;
      case (req)
        ReqTick: second_tick();
        ReqPoll: button_poll(mode, incr, conf);
        ReqScan: scan_digit();
        default: blink_lamps();
      endcase
      want.road_one = lamps[2:0];
      want.road_two = lamps[5:3];
      want.digit_sel = scan_pos - 2'd1;
      want.segments = segs;
      want.phase = phase_q;
      pending_lights.push_back(want);
    endfunction

    function void check_lights(lights_t got);
      lights_t want;
      if (pending_lights.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        mismatch_count++;
        return;
      end
      want = pending_lights.pop_front();
      if (got.road_one !== want.road_one) begin
        $error("road_one_lamps: expected %0h, actual %0h", want.road_one, got.road_one);
        mismatch_count++;
      end
      if (got.road_two !== want.road_two) begin
        $error("road_two_lamps: expected %0h, actual %0h", want.road_two, got.road_two);
        mismatch_count++;
      end
      if (got.digit_sel !== want.digit_sel) begin
        $error("digit_select: expected %0d, actual %0d", want.digit_sel, got.digit_sel);
        mismatch_count++;
      end
      if (got.segments !== want.segments) begin
        $error("segment_pattern: expected %0h, actual %0h", want.segments, got.segments);
        mismatch_count++;
      end
      if (got.phase !== want.phase) begin
        $error("current_phase: expected %0d, actual %0d", want.phase, got.phase);
        mismatch_count++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] req_type = ReqTick;
  logic       press_mode = 1'b0;
  logic       press_increase = 1'b0;
  logic       press_confirm = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] road_one_lamps;
  logic [2:0] road_two_lamps;
  logic [1:0] digit_select;
  logic [6:0] segment_pattern;
  logic [2:0] current_phase;

  light_scoreboard sb = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     stall_pct = 0;
  int unsigned     sent_count = 0;
  int unsigned     cycle_count = 0;
  bit              want_hold = 1'b0;

  traffic_light_controller dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .req_type_i       (req_type),
    .press_mode_i     (press_mode),
    .press_increase_i (press_increase),
    .press_confirm_i  (press_confirm),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .road_one_lamps_o (road_one_lamps),
    .road_two_lamps_o (road_two_lamps),
    .digit_select_o   (digit_select),
    .segment_pattern_o(segment_pattern),
    .current_phase_o  (current_phase)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_traffic_light_controller: FAIL");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] req, input logic mode, input logic incr,
                              input logic conf);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    press_mode <= mode;
    press_increase <= incr;
    press_confirm <= conf;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, mode, incr, conf);
    sent_count++;
  endtask

  task automatic send_random();
    send_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_background();
    case ($urandom_range(0, 2))
      0:       send_request(ReqTick, 1'b0, 1'b0, 1'b0);
      1:       send_request(ReqScan, 1'b0, 1'b0, 1'b0);
      default: send_request(ReqBlink, 1'b0, 1'b0, 1'b0);
    endcase
  endtask

  // automatic running: mostly second ticks with scans, blinks and empty polls
  task automatic run_traffic(input int unsigned beats);
    int unsigned pick;
    repeat (beats) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) send_request(ReqTick, 1'b0, 1'b0, 1'b0);
      else if (pick < 7) send_request(ReqScan, 1'b0, 1'b0, 1'b0);
      else if (pick < 8) send_request(ReqBlink, 1'b0, 1'b0, 1'b0);
      else send_request(ReqPoll, 1'b0, 1'b0, 1'b0);
    end
  endtask

  // walk red, amber and green edits; long increment runs reach the wrap and the clamp
  task automatic run_edit_session();
    int unsigned runs;
    repeat (3) begin
      send_request(ReqPoll, 1'b1, 1'b0, 1'b0);
      runs = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 100) : $urandom_range(0, 4);
      repeat (runs) begin
        if ($urandom_range(0, 3) == 0) send_background();
        send_request(ReqPoll, 1'b0, 1'b1, 1'b0);
      end
      if ($urandom_range(0, 3) != 0) send_request(ReqPoll, 1'b0, 1'b0, 1'b1);
    end
    send_request(ReqPoll, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic run_random(input int unsigned beats);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = sent_count + beats;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) run_traffic($urandom_range(1, 8));
      else if (pick < 85) run_edit_session();
      else repeat ($urandom_range(1, 4)) send_random();
    end
  endtask

  // receiving side: random stalls plus one long hold-off
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      if (want_hold && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        sb.check_lights({road_one_lamps, road_two_lamps, digit_select, segment_pattern,
                         current_phase});
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scan of the zeroed digit store and idle blink straight out of reset
    send_request(ReqScan, 1'b0, 1'b0, 1'b0);
    send_request(ReqBlink, 1'b0, 1'b0, 1'b0);
    send_request(ReqPoll, 1'b0, 1'b0, 1'b0);
    repeat (4) send_request(ReqScan, 1'b0, 1'b0, 1'b0);
    // run out road two, then both roads together
    repeat (6) send_request(ReqTick, 1'b0, 1'b0, 1'b0);
    // all three buttons in one poll are applied in order
    send_request(ReqPoll, 1'b1, 1'b1, 1'b1);
    repeat (2) send_request(ReqBlink, 1'b0, 1'b0, 1'b0);
    send_request(ReqPoll, 1'b0, 1'b1, 1'b0);
    send_request(ReqPoll, 1'b1, 1'b0, 1'b0);
    send_request(ReqBlink, 1'b0, 1'b0, 1'b0);
    send_request(ReqPoll, 1'b0, 1'b1, 1'b1);
    send_request(ReqPoll, 1'b1, 1'b0, 1'b0);
    send_request(ReqBlink, 1'b0, 1'b0, 1'b0);
    send_request(ReqPoll, 1'b0, 1'b0, 1'b1);
    send_request(ReqPoll, 1'b1, 1'b0, 1'b0);
    send_request(ReqTick, 1'b0, 1'b0, 1'b0);

    // keep offering beats while the output is held off so the block backs up
    want_hold = 1'b1;
    run_traffic(40);

    run_random(220);
    send_idle_pct = 64;
    run_random(220);
    send_idle_pct = 0;
    stall_pct = 64;
    run_random(220);
    send_idle_pct = 7;
    stall_pct = 7;
    run_random(220);

    in_valid <= 1'b0;
    while (sb.pending_lights.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_lights.size() == 0) begin
      $display("tb_traffic_light_controller: PASS");
    end else begin
      $display("tb_traffic_light_controller: FAIL");
    end
    $finish;
  end

endmodule

@@ traffic_light_controller.f @@
src/tlc_pkg.sv
src/traffic_light_controller.sv
verif/tb_traffic_light_controller.sv
